// ===== src/szos_pkg.sv =====
// Shared types, constants and the drive-state table for the scan-zone steering block.
package szos_pkg;

  localparam int DIST_W     = 16;
  localparam int IDX_W      = 12;
  localparam int SPEED_W    = 15;
  localparam int VEL_W      = 16;
  localparam int ZONES      = 5;
  localparam int ZONE_W     = 3;
  localparam int STATE_W    = 3;
  localparam int MASK_W     = ZONES;
  localparam int SIZE_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // Division of the ray count by five: multiply by a reciprocal and shift.
  localparam int DIV5_MUL_W = 16;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 16'hCCCD;
  localparam int DIV5_SHIFT = 18;
  localparam int DIV5_PROD_W = IDX_W + DIV5_MUL_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_COUNT     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [SPEED_W-1:0] RESET_LINEAR_SPEED  = 15'd300;
  localparam logic [SPEED_W-1:0] RESET_ANGULAR_SPEED = 15'd200;
  localparam logic [DIST_W-1:0]  RESET_CLEARANCE     = 16'd5000;
  localparam logic [DIST_W-1:0]  RESET_MAX_RANGE     = 16'd30000;
  localparam int                 RESET_RAY_COUNT_INT = 720;
  localparam logic [IDX_W-1:0]   RESET_RAY_COUNT     = IDX_W'(RESET_RAY_COUNT_INT);
  localparam logic [SIZE_W-1:0]  RESET_ZONE_SPAN     = SIZE_W'(RESET_RAY_COUNT_INT / ZONES);

  // Drive states.
  localparam logic [STATE_W-1:0] ST_FIND_WALL    = 3'd0;
  localparam logic [STATE_W-1:0] ST_TURN_LEFT    = 3'd1;
  localparam logic [STATE_W-1:0] ST_FOLLOW       = 3'd2;
  localparam logic [STATE_W-1:0] ST_SLOW_AHEAD   = 3'd3;
  localparam logic [STATE_W-1:0] ST_REVERSE_LEFT = 3'd4;

  localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(ZONES - 1);

  typedef struct packed {
    logic [SPEED_W-1:0] linear_speed;
    logic [SPEED_W-1:0] angular_speed;
    logic [DIST_W-1:0]  clearance;
    logic [DIST_W-1:0]  max_range;
    logic [IDX_W-1:0]   ray_count;
    logic [SIZE_W-1:0]  zone_span;
  } cfg_t;

  // One classified ray as it travels from the front to the back.
  typedef struct packed {
    logic [DIST_W-1:0] range_mm;
    logic [ZONE_W-1:0] zone;
    logic              first;
    logic              last;
  } ray_t;

  function automatic logic [STATE_W-1:0] state_of_mask(input logic [MASK_W-1:0] mask);
    logic [STATE_W-1:0] st;
    unique case (mask)
      5'd0, 5'd8, 5'd16, 5'd20, 5'd22, 5'd24, 5'd25, 5'd29: st = ST_FIND_WALL;
      5'd1:                                                  st = ST_FOLLOW;
      5'd9, 5'd10, 5'd11, 5'd17, 5'd18, 5'd26, 5'd27:        st = ST_SLOW_AHEAD;
      5'd31:                                                 st = ST_REVERSE_LEFT;
      default:                                               st = ST_TURN_LEFT;
    endcase
    return st;
  endfunction

endpackage

// ===== src/szos_front.sv =====
// Front part: tracks the ray position in the scan and tags each ray with zone and scan marks.
module szos_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [szos_pkg::DIST_W-1:0]  distance_mm,
  input  szos_pkg::cfg_t               cfg,
  output szos_pkg::ray_t               ray
);
  import szos_pkg::*;

  logic [IDX_W-1:0]  ray_index;
  logic [IDX_W-1:0]  ray_index_next;
  logic [IDX_W-1:0]  bound1, bound2, bound3, bound4;
  logic [IDX_W:0]    index_plus;
  logic              last;
  logic [ZONE_W-1:0] zone;

  // Zone k starts at k times the zone size; the last zone runs to the end of the scan.
  assign bound1 = IDX_W'(cfg.zone_span);
  assign bound2 = IDX_W'({cfg.zone_span, 1'b0});
  assign bound3 = bound1 + bound2;
  assign bound4 = IDX_W'({cfg.zone_span, 2'b00});

  always_comb begin
    priority if (ray_index >= bound4) begin
      zone = LAST_ZONE;
    end else if (ray_index >= bound3) begin
      zone = ZONE_W'(3);
    end else if (ray_index >= bound2) begin
      zone = ZONE_W'(2);
    end else if (ray_index >= bound1) begin
      zone = ZONE_W'(1);
    end else begin
      zone = ZONE_W'(0);
    end
  end

  assign index_plus     = {1'b0, ray_index} + (IDX_W + 1)'(1);
  assign last           = !(index_plus < {1'b0, cfg.ray_count});
  assign ray_index_next = last ? '0 : index_plus[IDX_W-1:0];

  assign ray.range_mm = distance_mm;
  assign ray.zone     = zone;
  assign ray.first    = (ray_index == '0);
  assign ray.last     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_index <= '0;
    end else if (accept) begin
      ray_index <= ray_index_next;
    end
  end

endmodule

// ===== src/szos_fifo.sv =====
// Short queue of classified rays between the front and the back.
module szos_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  szos_pkg::ray_t push_data,
  input  logic           pop,
  output szos_pkg::ray_t head,
  output logic           full,
  output logic           empty
);
  import szos_pkg::*;

  ray_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full  = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (FIFO_PTR_W + 1)'(1);
        2'b01:   count <= count - (FIFO_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/szos_back.sv =====
// Back part: updates zone minima and, at the end of a scan, picks the drive command.
module szos_back (
  input  logic                          clk,
  input  logic                          rst,
  input  szos_pkg::cfg_t                cfg,
  input  szos_pkg::ray_t                head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [szos_pkg::STATE_W-1:0]  steer_state,
  output logic [szos_pkg::VEL_W-1:0]    linear_velocity,
  output logic [szos_pkg::VEL_W-1:0]    angular_velocity,
  output logic [szos_pkg::MASK_W-1:0]   obstacle_mask,
  output logic                          unknown_case
);
  import szos_pkg::*;

  logic [DIST_W-1:0]  zmin [ZONES];
  logic [DIST_W-1:0]  zmin_next [ZONES];
  logic [STATE_W-1:0] cur_state;
  logic [STATE_W-1:0] state_next;
  logic [MASK_W-1:0]  mask;
  logic               unknown;
  logic               slot_free;
  logic [VEL_W-1:0]   lin_ext, ang_ext, lin_cmd, ang_cmd;

  assign slot_free = !out_valid || !out_stall;
  // A ray that ends a scan waits until the output register can take its result.
  assign pop = !empty && (!head.last || slot_free);

  // A scan's first ray starts every zone again from the sensor maximum.
  always_comb begin
    for (int k = 0; k < ZONES; k++) begin
      zmin_next[k] = head.first ? cfg.max_range : zmin[k];
      if (head.zone == ZONE_W'(k) && head.range_mm < zmin_next[k]) begin
        zmin_next[k] = head.range_mm;
      end
      mask[k] = zmin_next[k] < cfg.clearance;
    end
  end

  always_comb begin
    unknown = 1'b0;
    for (int k = 0; k < ZONES; k++) begin
      if (zmin_next[k] == cfg.clearance) begin
        unknown = 1'b1;
      end
    end
  end

  // A zone sitting exactly on the threshold leaves the previous state in force.
  assign state_next = unknown ? cur_state : state_of_mask(mask);

  assign lin_ext = {1'b0, cfg.linear_speed};
  assign ang_ext = {1'b0, cfg.angular_speed};

  always_comb begin
    unique case (state_next)
      ST_FIND_WALL: begin
        lin_cmd = lin_ext;
        ang_cmd = VEL_W'(0) - ang_ext;
      end
      ST_TURN_LEFT: begin
        lin_cmd = '0;
        ang_cmd = ang_ext;
      end
      ST_FOLLOW: begin
        lin_cmd = lin_ext;
        ang_cmd = '0;
      end
      ST_SLOW_AHEAD: begin
        lin_cmd = lin_ext >> 1;
        ang_cmd = '0;
      end
      default: begin
        lin_cmd = VEL_W'(0) - lin_ext;
        ang_cmd = ang_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < ZONES; k++) begin
        zmin[k] <= zmin_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= ST_FIND_WALL;
      out_valid <= 1'b0;
    end else begin
      if (pop && head.last) begin
        cur_state <= state_next;
      end
      if (slot_free) begin
        out_valid <= pop && head.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      steer_state      <= state_next;
      linear_velocity  <= lin_cmd;
      angular_velocity <= ang_cmd;
      obstacle_mask    <= mask;
      unknown_case     <= unknown;
    end
  end

endmodule

// ===== src/scan_zone_obstacle_steering.sv =====
// Top level of the scan-zone obstacle steering block with its configuration registers.
//
// Usage:
//   Range samples enter on the input channel (in_valid, in_stall, distance_mm), one ray
//   per transfer in scan order. Each ray is tagged with its zone and queued in a
//   four-entry queue; the back part folds it into the zone minima, one ray per cycle
//   unless the queue is empty or an end-of-scan ray waits for the output register.
//   The last ray of a scan produces one transfer on the output channel (out_valid,
//   out_stall) carrying the drive state, velocity commands, obstacle mask and the
//   unknown flag. All other rays produce nothing. Throughput is one ray per cycle
//   while the queue is not full. The scan's last ray is written into the queue and,
//   once at its head with the output register free, is loaded into the output register.
//   When the receiver stalls, the output register holds its result; later rays keep
//   flowing into the zone minima, and a further end-of-scan ray waits in the queue.
//   in_stall rises only when the queue is full.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next edge;
//   writing the ray count also latches the zone size, ray count divided by five.
//   Reset restores the default configuration, empties the queue, restarts the scan at
//   its first ray and sets the drive state to find wall. No clearing pass is needed.
module scan_zone_obstacle_steering (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [szos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [szos_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [szos_pkg::DIST_W-1:0]       distance_mm,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [szos_pkg::STATE_W-1:0]      steer_state,
  output logic signed [szos_pkg::VEL_W-1:0] linear_velocity,
  output logic signed [szos_pkg::VEL_W-1:0] angular_velocity,
  output logic [szos_pkg::MASK_W-1:0]       obstacle_mask,
  output logic                              unknown_case
);
  import szos_pkg::*;

  cfg_t                   cfg;
  ray_t                   front_ray;
  ray_t                   head;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   pop;
  logic [DIV5_PROD_W-1:0] div5_prod;
  logic [VEL_W-1:0]       lin_bits;
  logic [VEL_W-1:0]       ang_bits;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  assign div5_prod = DIV5_PROD_W'(cfg_data[IDX_W-1:0]) * DIV5_PROD_W'(DIV5_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_speed  <= RESET_LINEAR_SPEED;
      cfg.angular_speed <= RESET_ANGULAR_SPEED;
      cfg.clearance     <= RESET_CLEARANCE;
      cfg.max_range     <= RESET_MAX_RANGE;
      cfg.ray_count     <= RESET_RAY_COUNT;
      cfg.zone_span     <= RESET_ZONE_SPAN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINEAR_SPEED:  cfg.linear_speed  <= cfg_data[SPEED_W-1:0];
        REG_ANGULAR_SPEED: cfg.angular_speed <= cfg_data[SPEED_W-1:0];
        REG_CLEARANCE:     cfg.clearance     <= cfg_data[DIST_W-1:0];
        REG_MAX_RANGE:     cfg.max_range     <= cfg_data[DIST_W-1:0];
        REG_RAY_COUNT: begin
          cfg.ray_count <= cfg_data[IDX_W-1:0];
          cfg.zone_span <= div5_prod[DIV5_SHIFT+SIZE_W-1:DIV5_SHIFT];
        end
        default: ;
      endcase
    end
  end

  szos_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .distance_mm (distance_mm),
    .cfg         (cfg),
    .ray         (front_ray)
  );

  szos_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_ray),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  szos_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .steer_state      (steer_state),
    .linear_velocity  (lin_bits),
    .angular_velocity (ang_bits),
    .obstacle_mask    (obstacle_mask),
    .unknown_case     (unknown_case)
  );

  assign linear_velocity  = signed'(lin_bits);
  assign angular_velocity = signed'(ang_bits);

endmodule

// ===== bench/scan_zone_obstacle_steering_test.sv =====
// Self-checking testbench for the scan-zone obstacle steering block.
module scan_zone_obstacle_steering_test;
  import szos_pkg::*;

  typedef struct packed {
    logic [STATE_W-1:0]        state;
    logic signed [VEL_W-1:0]   lin;
    logic signed [VEL_W-1:0]   ang;
    logic [MASK_W-1:0]         mask;
    logic                      unknown;
  } steer_cmd_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [DIST_W-1:0]      distance_mm = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATE_W-1:0]     steer_state;
  logic signed [VEL_W-1:0] linear_velocity;
  logic signed [VEL_W-1:0] angular_velocity;
  logic [MASK_W-1:0]      obstacle_mask;
  logic                   unknown_case;

  scan_zone_obstacle_steering DUT (.*);

  // Predictor state: configuration copy and scan progress.
  logic [SPEED_W-1:0]     lin_cfg;
  logic [SPEED_W-1:0]     ang_cfg;
  logic [DIST_W-1:0]      safety_cfg;
  logic [DIST_W-1:0]      range_cfg;
  logic [IDX_W-1:0]       ray_cfg;
  logic [DIST_W-1:0]      zone_min [ZONES];
  int                     ray_pos;
  logic [STATE_W-1:0]     held_state;

  logic [DIST_W-1:0]      ray_queue [$];
  steer_cmd_t             steer_expected [$];
  int                     rays_outstanding = 0;
  int                     rays_queued = 0;
  int                     commands_seen = 0;
  int                     ties_seen = 0;
  int                     mismatch_count = 0;
  int                     phase_count = 0;
  int                     next_pos = 0;

  int                     in_gap_max = 0;
  int                     in_gap_left = 0;
  int                     out_stall_max = 0;
  int                     out_hold_left = 0;
  logic                   ray_taken = 1'b0;
  logic                   out_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int zone_of_ray(input int pos, input logic [IDX_W-1:0] count);
    int size;
    size = int'(count) / ZONES;
    if (size == 0) return ZONES - 1;
    return (pos / size >= ZONES - 1) ? ZONES - 1 : pos / size;
  endfunction

  function automatic logic [STATE_W-1:0] steer_table(input logic [MASK_W-1:0] m);
    case (m)
      5'd1:  return ST_FOLLOW;
      5'd31: return ST_REVERSE_LEFT;
      5'd9, 5'd10, 5'd11, 5'd17, 5'd18, 5'd26, 5'd27: return ST_SLOW_AHEAD;
      5'd0, 5'd8, 5'd16, 5'd20, 5'd22, 5'd24, 5'd25, 5'd29: return ST_FIND_WALL;
      default: return ST_TURN_LEFT;
    endcase
  endfunction

  // Folds one accepted ray into the zone minima; at the end of a scan it
  // queues the steering command the block must produce.
  function automatic void fold_ray(input logic [DIST_W-1:0] d);
    int         z;
    logic [MASK_W-1:0] mask;
    bit         tie;
    steer_cmd_t c;
    if (ray_pos == 0) begin
      for (int k = 0; k < ZONES; k++) zone_min[k] = range_cfg;
    end
    z = zone_of_ray(ray_pos, ray_cfg);
    if (d < zone_min[z]) zone_min[z] = d;
    if (ray_pos + 1 < int'(ray_cfg)) begin
      ray_pos++;
      return;
    end
    ray_pos = 0;
    mask = '0;
    tie = 1'b0;
    for (int k = 0; k < ZONES; k++) begin
      if (zone_min[k] < safety_cfg) mask[k] = 1'b1;
      else if (zone_min[k] == safety_cfg) tie = 1'b1;
    end
    // A zone sitting exactly on the threshold leaves the drive state alone.
    if (!tie) held_state = steer_table(mask);
    c.state = held_state;
    c.mask = mask;
    c.unknown = tie;
    case (held_state)
      ST_FIND_WALL: begin
        c.lin = VEL_W'(lin_cfg);
        c.ang = VEL_W'(-int'(ang_cfg));
      end
      ST_TURN_LEFT: begin
        c.lin = '0;
        c.ang = VEL_W'(ang_cfg);
      end
      ST_FOLLOW: begin
        c.lin = VEL_W'(lin_cfg);
        c.ang = '0;
      end
      ST_SLOW_AHEAD: begin
        c.lin = VEL_W'(lin_cfg >> 1);
        c.ang = '0;
      end
      default: begin
        c.lin = VEL_W'(-int'(lin_cfg));
        c.ang = VEL_W'(ang_cfg);
      end
    endcase
    if (tie) ties_seen++;
    steer_expected.push_back(c);
  endfunction

  function automatic void check_command();
    steer_cmd_t want;
    if (steer_expected.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: steering result with none expected: state %0d lin %0d ang %0d",
                 steer_state, linear_velocity, angular_velocity);
      return;
    end
    want = steer_expected.pop_front();
    commands_seen++;
    if (steer_state !== want.state || linear_velocity !== want.lin ||
        angular_velocity !== want.ang || obstacle_mask !== want.mask ||
        unknown_case !== want.unknown) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("ERROR: command %0d expected state %0d lin %0d ang %0d mask %b unk %b,",
                 commands_seen, want.state, $signed(want.lin), $signed(want.ang),
                 want.mask, want.unknown);
        $display("       got state %0d lin %0d ang %0d mask %b unk %b",
                 steer_state, linear_velocity, angular_velocity,
                 obstacle_mask, unknown_case);
      end
    end
  endfunction

  // Ray driver: holds each ray until its transfer, then waits its drawn gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || ray_taken) begin
      if (in_gap_left > 0) begin
        in_valid <= 1'b0;
        in_gap_left--;
      end else if (ray_queue.size() > 0) begin
        distance_mm <= ray_queue.pop_front();
        in_valid <= 1'b1;
        in_gap_left = $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls a drawn number of cycles before each transfer.
  always @(negedge clk) begin
    if (out_taken) out_hold_left = $urandom_range(0, out_stall_max);
    out_stall <= (out_hold_left > 0);
    if (out_hold_left > 0) out_hold_left--;
  end

  always @(posedge clk) begin
    ray_taken <= !rst && in_valid && !in_stall;
    out_taken <= !rst && out_valid && !out_stall;
    if (!rst && in_valid && !in_stall) begin
      fold_ray(distance_mm);
      rays_outstanding--;
    end
    if (!rst && out_valid && !out_stall) check_command();
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_LINEAR_SPEED:  lin_cfg = data[SPEED_W-1:0];
      REG_ANGULAR_SPEED: ang_cfg = data[SPEED_W-1:0];
      REG_CLEARANCE:     safety_cfg = data;
      REG_MAX_RANGE:     range_cfg = data;
      REG_RAY_COUNT:     ray_cfg = data[IDX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_ray(input logic [DIST_W-1:0] d);
    ray_queue.push_back(d);
    rays_outstanding++;
    rays_queued++;
  endtask

  task automatic queue_five(input logic [DIST_W-1:0] d0, d1, d2, d3, d4);
    push_ray(d0);
    push_ray(d1);
    push_ray(d2);
    push_ray(d3);
    push_ray(d4);
  endtask

  // Waits until every ray is folded in and every command has been checked,
  // then lets the queue and output register of the block empty out.
  task automatic settle();
    while (rays_outstanding != 0 || steer_expected.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Queues rays from the current scan position; cap 0 runs to the end of the scan.
  // Rays in zones picked as blocked fall below the threshold now and then.
  task automatic queue_scan(input int cap);
    logic [MASK_W-1:0] blocked;
    bit                noisy;
    bit                done;
    int                sent;
    logic [DIST_W-1:0] d;
    blocked = MASK_W'($urandom);
    noisy = ($urandom_range(0, 6) == 0);
    done = 1'b0;
    sent = 0;
    while (!done) begin
      if (noisy)
        d = DIST_W'($urandom);
      else if ($urandom_range(0, 199) < 2)
        d = safety_cfg;
      else if (blocked[zone_of_ray(next_pos, ray_cfg)] && $urandom_range(0, 2) == 0)
        d = (safety_cfg == 0 || $urandom_range(0, 3) == 0) ? '0 :
            DIST_W'($urandom_range(0, int'(safety_cfg) - 1));
      else
        d = (safety_cfg == 16'hFFFF || $urandom_range(0, 7) == 0) ? 16'hFFFF :
            DIST_W'($urandom_range(int'(safety_cfg) + 1, 65535));
      push_ray(d);
      sent++;
      if (next_pos + 1 < int'(ray_cfg)) begin
        next_pos++;
      end else begin
        next_pos = 0;
        done = 1'b1;
      end
      if (cap != 0 && sent >= cap) done = 1'b1;
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_speed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hFFFF;
      default: return CFG_DATA_W'($urandom_range(1, 65534));
    endcase
  endfunction

  initial begin
    int rc;
    int scans;
    lin_cfg = RESET_LINEAR_SPEED;
    ang_cfg = RESET_ANGULAR_SPEED;
    safety_cfg = RESET_CLEARANCE;
    range_cfg = RESET_MAX_RANGE;
    ray_cfg = RESET_RAY_COUNT;
    ray_pos = 0;
    held_state = ST_FIND_WALL;
    for (int k = 0; k < ZONES; k++) zone_min[k] = RESET_MAX_RANGE;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed part: one ray per zone, speeds and thresholds still at reset.
    write_reg(REG_RAY_COUNT, 16'd5);
    queue_five(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_five(16'd4999, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Exact threshold in zone two must keep the follow state.
    queue_five(16'hFFFF, 16'hFFFF, 16'd5000, 16'hFFFF, 16'hFFFF);
    queue_five(16'd100, 16'hFFFF, 16'hFFFF, 16'd100, 16'hFFFF);
    settle();
    // Tiny scans: every ray lands in the last zone, counts 0 and 1 end a scan per ray.
    write_reg(REG_RAY_COUNT, 16'd1);
    push_ray(16'hFFFF);
    settle();
    write_reg(REG_RAY_COUNT, 16'd0);
    push_ray(16'd0);
    settle();
    write_reg(REG_RAY_COUNT, 16'd3);
    push_ray(16'd9000);
    push_ray(16'd4000);
    push_ray(16'd12000);
    settle();
    // Ray count lowered below the current position: the next ray ends the scan.
    write_reg(REG_RAY_COUNT, 16'd10);
    repeat (6) push_ray(DIST_W'($urandom));
    settle();
    write_reg(REG_RAY_COUNT, 16'd5);
    push_ray(16'd7000);
    settle();
    // Max range changed mid-scan only applies from the next scan on.
    push_ray(16'hFFFF);
    push_ray(16'hFFFF);
    settle();
    write_reg(REG_MAX_RANGE, 16'd100);
    queue_five(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_ray(16'hFFFF);
    push_ray(16'hFFFF);
    push_ray(16'hFFFF);
    settle();

    // Random phases: new settings, then whole scans and sometimes a cut-off one.
    while (rays_queued < 1700 || commands_seen < 60) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if (phase_count == 0 || $urandom_range(0, 1) == 1)
        write_reg(REG_LINEAR_SPEED, pick_speed());
      if (phase_count == 0 || $urandom_range(0, 1) == 1)
        write_reg(REG_ANGULAR_SPEED, pick_speed());
      if (phase_count == 0 || $urandom_range(0, 1) == 1)
        write_reg(REG_CLEARANCE, pick_level());
      if (phase_count == 0 || $urandom_range(0, 1) == 1)
        write_reg(REG_MAX_RANGE, ($urandom_range(0, 7) == 0) ? safety_cfg : pick_level());
      if (phase_count == 0 || phase_count == 4 || ray_cfg > 300 ||
          $urandom_range(0, 1) == 1) begin
        if (phase_count == 4) begin
          rc = 640;
          in_gap_max = 0;
        end else begin
          case ($urandom_range(0, 9))
            0: rc = $urandom_range(0, 4);
            1: rc = $urandom_range(41, 300);
            default: rc = $urandom_range(5, 40);
          endcase
        end
        // Upper data bits beyond the ray count width are junk the block drops.
        write_reg(REG_RAY_COUNT, CFG_DATA_W'(rc) | CFG_DATA_W'($urandom_range(0, 15) << IDX_W));
      end
      next_pos = ray_pos;
      scans = (ray_cfg > 300) ? 1 : $urandom_range(1, 4);
      repeat (scans) queue_scan(0);
      if ($urandom_range(0, 3) == 0) queue_scan($urandom_range(1, 30));
      settle();
      phase_count++;
    end

    settle();
    $display("Sent %0d rays over %0d random phases; checked %0d steering commands.",
             rays_queued, phase_count, commands_seen);
    $display("%0d commands came from a zone exactly on the threshold; %0d mismatches.",
             ties_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d rays and %0d commands still pending.",
             rays_outstanding, steer_expected.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
